// ===== sv/u8cp_pkg.sv =====
// Package for the UTF-8 to code point decoder.
// Holds the byte class masks, the substitute character and the result type.
// Depends on nothing; every other file of the block uses it by scoped names.
package u8cp_pkg;

  localparam int unsigned ByteW  = 8;
  localparam int unsigned CpW    = 21;
  localparam int unsigned CountW = 16;
  localparam int unsigned AccW   = 15;
  localparam int unsigned PendW  = 2;

  // Output tdata carries the code point and the count, padded to whole bytes.
  localparam int unsigned OutDataRawW = CpW + CountW;
  localparam int unsigned OutDataW    = ((OutDataRawW + 7) / 8) * 8;

  // Byte class masks and the patterns they are compared against.
  localparam logic [ByteW-1:0] Lead2Mask = 8'hE0;
  localparam logic [ByteW-1:0] Lead2Pat  = 8'hC0;
  localparam logic [ByteW-1:0] Lead3Mask = 8'hF0;
  localparam logic [ByteW-1:0] Lead3Pat  = 8'hE0;
  localparam logic [ByteW-1:0] Lead4Mask = 8'hF8;
  localparam logic [ByteW-1:0] Lead4Pat  = 8'hF0;
  localparam logic [ByteW-1:0] ContMask  = 8'hC0;
  localparam logic [ByteW-1:0] ContPat   = 8'h80;
  localparam logic [ByteW-1:0] HighBit   = 8'h80;
  localparam logic [ByteW-1:0] Payload2  = 8'h1F;
  localparam logic [ByteW-1:0] Payload3  = 8'h0F;
  localparam logic [ByteW-1:0] Payload4  = 8'h07;
  localparam logic [ByteW-1:0] ContBits  = 8'h3F;
  localparam logic [ByteW-1:0] AsciiBits = 8'h7F;

  // Character emitted in place of a malformed byte.
  localparam logic [CpW-1:0] SubstChar = 21'h00002A;

  // Continuation bytes still expected after each lead byte.
  localparam logic [PendW-1:0] PendNone  = 2'd0;
  localparam logic [PendW-1:0] PendOne   = 2'd1;
  localparam logic [PendW-1:0] PendTwo   = 2'd2;
  localparam logic [PendW-1:0] PendThree = 2'd3;

  typedef struct packed {
    logic [CpW-1:0]    code_point;
    logic              invalid;
    logic              end_of_string;
    logic [CountW-1:0] count;
  } result_t;

endpackage

// ===== sv/utf8_to_code_point_decoder.sv =====
// UTF-8 to code point decoder. One byte of a zero-terminated string enters per
// transaction on the slave side, and one byte can be accepted in every clock
// cycle unless a stalled result register holds it back; each byte is held in
// the input register, its result in the result register. Bytes that only open or
// extend a multi-byte sequence give no result. A zero byte gives a result with
// tlast high and the string's code point count, then decoding restarts. Bad
// bytes give '*' with tuser high. The limit register may be written only while
// the block is idle; cfg_ready is always high. No clearing pass follows reset.
// Uses u8cp_pkg, u8cp_in_stage, u8cp_decode and u8cp_out_reg.
module utf8_to_code_point_decoder (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          s_tvalid,
  output logic                          s_tready,
  input  logic [u8cp_pkg::ByteW-1:0]    s_tdata,   // [7:0] byte_in
  output logic                          m_tvalid,
  input  logic                          m_tready,
  output logic [u8cp_pkg::OutDataW-1:0] m_tdata,   // [20:0] code_point, [36:21] count
  output logic                          m_tlast,   // end_of_string
  output logic                          m_tuser,   // [0] invalid
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [u8cp_pkg::CountW-1:0]   cfg_data   // max_code_points
);

  logic                       item_valid;
  logic [u8cp_pkg::ByteW-1:0] item_byte;
  logic                       advance;
  logic                       has_result;
  u8cp_pkg::result_t          result;

  assign cfg_ready = 1'b1;

  // A held byte moves on unless its result would meet a stalled result register.
  assign advance = item_valid && (!m_tvalid || m_tready || !has_result);

  u8cp_in_stage u_in (
    .clk        (clk),
    .rst        (rst),
    .s_tvalid   (s_tvalid),
    .s_tready   (s_tready),
    .s_tdata    (s_tdata),
    .advance    (advance),
    .item_valid (item_valid),
    .item_byte  (item_byte)
  );

  u8cp_decode u_dec (
    .clk        (clk),
    .rst        (rst),
    .cfg_valid  (cfg_valid),
    .cfg_data   (cfg_data),
    .item_valid (item_valid),
    .item_byte  (item_byte),
    .advance    (advance),
    .has_result (has_result),
    .result     (result)
  );

  u8cp_out_reg u_out (
    .clk      (clk),
    .rst      (rst),
    .load     (advance && has_result),
    .result   (result),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast),
    .m_tuser  (m_tuser)
  );

endmodule

// ===== sv/u8cp_in_stage.sv =====
// Input register of the UTF-8 decoder.
// Holds one accepted byte until the decode stage moves it on; uses u8cp_pkg.
module u8cp_in_stage (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      s_tvalid,
  output logic                      s_tready,
  input  logic [u8cp_pkg::ByteW-1:0] s_tdata,   // [7:0] byte_in
  input  logic                      advance,
  output logic                      item_valid,
  output logic [u8cp_pkg::ByteW-1:0] item_byte
);

  // The register is free when empty or when its byte moves on this cycle.
  assign s_tready = !item_valid || advance;

  // Valid flag follows the slave side whenever the register can take a byte.
  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (s_tready) begin
      item_valid <= s_tvalid;
    end
  end

  // Payload needs no reset.
  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      item_byte <= s_tdata;
    end
  end

endmodule

// ===== sv/u8cp_decode.sv =====
// Decode stage of the UTF-8 decoder: limit register, sequence state and the
// single-pass classification of one byte into at most one result; uses u8cp_pkg.
module u8cp_decode (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_valid,
  input  logic [u8cp_pkg::CountW-1:0] cfg_data,
  input  logic                        item_valid,
  input  logic [u8cp_pkg::ByteW-1:0]  item_byte,
  input  logic                        advance,
  output logic                        has_result,
  output u8cp_pkg::result_t           result
);

  logic [u8cp_pkg::CountW-1:0] max_code_points;
  logic [u8cp_pkg::PendW-1:0]  bytes_pending;
  logic [u8cp_pkg::PendW-1:0]  bytes_pending_next;
  logic [u8cp_pkg::AccW-1:0]   partial_value;
  logic [u8cp_pkg::AccW-1:0]   partial_value_next;
  logic [u8cp_pkg::CountW-1:0] emitted_count;
  logic [u8cp_pkg::CountW-1:0] emitted_count_next;
  logic [u8cp_pkg::CountW-1:0] count_inc;
  logic [u8cp_pkg::CpW-1:0]    shifted_value;
  logic [u8cp_pkg::PendW-1:0]  pending_dec;

  assign count_inc     = emitted_count + 16'd1;
  assign shifted_value = {partial_value, item_byte[5:0]};
  assign pending_dec   = bytes_pending - 2'd1;

  // Limit register: user writes only while the block is idle; not enforced here.
  always_ff @(posedge clk) begin
    if (rst) begin
      max_code_points <= '1;
    end else if (cfg_valid) begin
      max_code_points <= cfg_data;
    end
  end

  // Classify the byte and work out the result and the next state.
  always_comb begin
    bytes_pending_next = bytes_pending;
    partial_value_next = partial_value;
    emitted_count_next = emitted_count;
    has_result         = 1'b0;
    result             = '0;
    priority if (item_byte == '0) begin
      // Terminator: report the total and restart.
      has_result           = 1'b1;
      result.end_of_string = 1'b1;
      result.count         = emitted_count;
      bytes_pending_next   = u8cp_pkg::PendNone;
      partial_value_next   = '0;
      emitted_count_next   = '0;
    end else if (emitted_count >= max_code_points) begin
      // Limit reached: the byte is dropped.
    end else if (bytes_pending == u8cp_pkg::PendNone) begin
      priority if ((item_byte & u8cp_pkg::Lead2Mask) == u8cp_pkg::Lead2Pat) begin
        partial_value_next = {7'd0, item_byte & u8cp_pkg::Payload2};
        bytes_pending_next = u8cp_pkg::PendOne;
      end else if ((item_byte & u8cp_pkg::Lead3Mask) == u8cp_pkg::Lead3Pat) begin
        partial_value_next = {7'd0, item_byte & u8cp_pkg::Payload3};
        bytes_pending_next = u8cp_pkg::PendTwo;
      end else if ((item_byte & u8cp_pkg::Lead4Mask) == u8cp_pkg::Lead4Pat) begin
        partial_value_next = {7'd0, item_byte & u8cp_pkg::Payload4};
        bytes_pending_next = u8cp_pkg::PendThree;
      end else if ((item_byte & u8cp_pkg::HighBit) == u8cp_pkg::HighBit) begin
        // Stray continuation or illegal high byte.
        has_result         = 1'b1;
        result.code_point  = u8cp_pkg::SubstChar;
        result.invalid     = 1'b1;
        result.count       = count_inc;
        emitted_count_next = count_inc;
      end else begin
        has_result         = 1'b1;
        result.code_point  = {13'd0, item_byte & u8cp_pkg::AsciiBits};
        result.count       = count_inc;
        emitted_count_next = count_inc;
      end
    end else if ((item_byte & u8cp_pkg::ContMask) == u8cp_pkg::ContPat) begin
      // Continuation byte: shift in six bits, emit on the last one.
      bytes_pending_next = pending_dec;
      if (pending_dec != u8cp_pkg::PendNone) begin
        partial_value_next = shifted_value[u8cp_pkg::AccW-1:0];
      end else begin
        partial_value_next = '0;
        has_result         = 1'b1;
        result.code_point  = shifted_value;
        result.count       = count_inc;
        emitted_count_next = count_inc;
      end
    end else begin
      // Missing continuation prefix: the byte is consumed as a bad one.
      bytes_pending_next = u8cp_pkg::PendNone;
      partial_value_next = '0;
      has_result         = 1'b1;
      result.code_point  = u8cp_pkg::SubstChar;
      result.invalid     = 1'b1;
      result.count       = count_inc;
      emitted_count_next = count_inc;
    end
  end

  // Sequence state moves only when the held byte leaves the input register.
  always_ff @(posedge clk) begin
    if (rst) begin
      bytes_pending <= u8cp_pkg::PendNone;
      partial_value <= '0;
      emitted_count <= '0;
    end else if (item_valid && advance) begin
      bytes_pending <= bytes_pending_next;
      partial_value <= partial_value_next;
      emitted_count <= emitted_count_next;
    end
  end

endmodule

// ===== sv/u8cp_out_reg.sv =====
// Result register of the UTF-8 decoder, driving the master-side stream.
// Packs the result fields onto tdata, tlast and tuser; uses u8cp_pkg.
module u8cp_out_reg (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          load,
  input  u8cp_pkg::result_t             result,
  output logic                          m_tvalid,
  input  logic                          m_tready,
  output logic [u8cp_pkg::OutDataW-1:0] m_tdata,
  output logic                          m_tlast,
  output logic                          m_tuser
);

  u8cp_pkg::result_t held;

  // Valid flag: set on a new result, cleared once the transaction completes.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      held <= result;
    end
  end

  assign m_tdata = {{(u8cp_pkg::OutDataW - u8cp_pkg::OutDataRawW){1'b0}},
                    held.count, held.code_point};
  assign m_tlast = held.end_of_string;
  assign m_tuser = held.invalid;

endmodule

// ===== sv/u8cp_checker.sv =====
// Port checker for the UTF-8 decoder, with the bind that attaches it.
// Sees only the top level's ports; uses u8cp_pkg for field widths.
module u8cp_checker (
  input logic                          clk,
  input logic                          rst,
  input logic                          m_tvalid,
  input logic                          m_tready,
  input logic [u8cp_pkg::OutDataW-1:0] m_tdata,
  input logic                          m_tlast,
  input logic                          m_tuser
);

  // No result is offered in the cycle after reset.
  assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("result offered straight after reset");

  // An end result carries a zero code point and no invalid flag.
  assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tlast) |-> (m_tdata[20:0] == 21'd0 && !m_tuser))
    else $error("end result with code point or invalid flag");

  // A substituted result always carries the '*' character.
  assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tuser) |-> (m_tdata[20:0] == 21'd42 && !m_tlast))
    else $error("invalid result without substitute character");

  // Every code point result counts at least itself.
  assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tlast) |-> (m_tdata[36:21] != 16'd0))
    else $error("code point result with zero count");

  // A stalled result holds.
  assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
    else $error("stalled result changed");

endmodule

bind utf8_to_code_point_decoder u8cp_checker u_chk (
  .clk      (clk),
  .rst      (rst),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tlast  (m_tlast),
  .m_tuser  (m_tuser)
);
